// File: sv/qap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qap_pkg: shared types and constants of the QAP evaluator
// Field widths, command codes, sequencer states and channel payloads.
// ----------------------------------------------------------------------------
package qap_pkg;

   localparam int QAP_MAX_SIZE   = 16;
   localparam int QAP_ENTRY_BITS = 16;

   localparam int MODE_BITS   = 3;
   localparam int INDEX_BITS  = 4;
   localparam int VALUE_BITS  = 16;
   localparam int LOC_BITS    = 4;
   localparam int SIZE_BITS   = 5;
   localparam int ANSWER_BITS = 40;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

   localparam logic [MODE_BITS-1:0] MODE_COST      = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_DIST      = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_ASSIGN    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_OBJECTIVE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_SWAP      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_SWAP_R,
      ST_SWAP_S,
      ST_STREAM,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [INDEX_BITS-1:0] row_index;
      logic [INDEX_BITS-1:0] col_index;
      logic [VALUE_BITS-1:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [ANSWER_BITS-1:0] answer;
   } rsp_payload_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] problem_size;
   } csr_payload_type;

endpackage

// File: sv/qap_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qap_chan_if: valid/ready channel
// Carries one payload per transfer; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface qap_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// File: sv/qap_objective_and_swap_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qap_objective_and_swap_delta: quadratic assignment evaluator
// Holds cost and distance matrices and a facility-to-location assignment, and
// returns the objective or the delta of a swap of two positions.
// ----------------------------------------------------------------------------
// One command is taken at a time; one response transfer follows each command.
// A write of a cost, distance or assignment entry goes to the finish state,
// and its response is loaded into the output register once that register is
// free. The objective streams one facility pair per cycle through one shared
// subtract/multiply/accumulate pipeline, with a row state ahead of each row to
// fetch that row's location. The swap delta streams one facility per cycle
// after two location fetches. The next command is taken in the cycle after
// the response is loaded into the output register. A response waiting in the
// output register does not block the next command; the following result waits
// until it leaves. The matrix and assignment stores hold no reset value; read
// them only after writing.
module qap_objective_and_swap_delta
   import qap_pkg::*;
#(
   parameter int MAX_SIZE   = QAP_MAX_SIZE,
   parameter int ENTRY_BITS = QAP_ENTRY_BITS
) (
   input logic         clock,
   input logic         reset,
   qap_chan_if.sink    req_chan,
   qap_chan_if.source  rsp_chan,
   qap_chan_if.sink    csr_chan
);

   localparam int IDX_BITS  = $clog2(MAX_SIZE);
   localparam int CNT_BITS  = $clog2(MAX_SIZE + 1);
   localparam int NW        = (CNT_BITS > SIZE_BITS) ? CNT_BITS : SIZE_BITS;
   localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int DIFF_BITS = ENTRY_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int ACC_BITS  = PROD_BITS + ADDR_BITS;
   localparam int SAT_BITS  = (ACC_BITS > ANSWER_BITS) ? ACC_BITS : ANSWER_BITS;

   localparam logic signed [ANSWER_BITS-1:0] ANS_MAX = {1'b0, {(ANSWER_BITS-1){1'b1}}};
   localparam logic signed [ANSWER_BITS-1:0] ANS_MIN = {1'b1, {(ANSWER_BITS-1){1'b0}}};
   localparam logic signed [SAT_BITS-1:0]    SAT_MAX = SAT_BITS'(ANS_MAX);
   localparam logic signed [SAT_BITS-1:0]    SAT_MIN = SAT_BITS'(ANS_MIN);

   function automatic logic [ADDR_BITS-1:0] mat_addr(input logic [IDX_BITS-1:0] a,
                                                     input logic [IDX_BITS-1:0] b);
      mat_addr = ADDR_BITS'(ADDR_BITS'(a) * ADDR_BITS'(MAX_SIZE) + ADDR_BITS'(b));
   endfunction

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [NW-1:0]        n_ff, n_in;
   logic                 swap_ff, swap_in;
   logic [IDX_BITS-1:0]  r_ff, r_in, s_ff, s_in;
   logic [IDX_BITS-1:0]  i_ff, i_in, j_ff, j_in;
   logic [LOC_BITS-1:0]  pr_ff, pr_in;

   logic                 v1_ff, v1_in, v2_ff, v3_ff, v4_ff;
   logic [IDX_BITS-1:0]  a1_ff, a1_in, b1_ff, b1_in;
   logic                 dva2_ff, dva2_in, dvb2_ff, dvb2_in;
   logic signed [DIFF_BITS-1:0] cdiff3_ff, cdiff3_in, ddiff3_ff, ddiff3_in;
   logic signed [PROD_BITS-1:0] prod4_ff, prod4_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ANSWER_BITS-1:0] answer_ff, answer_in;

   logic                 req_fire, csr_fire, load;
   logic                 row_ok, col_ok;
   logic [NW-1:0]        n_calc;
   logic                 cmd_obj_go, cmd_swap_go;
   logic [IDX_BITS-1:0]  n_last, n_last2;
   logic                 pipe_busy;

   logic                 cost_we, dist_we, asg_we;
   logic [ADDR_BITS-1:0] wr_mat_addr;
   logic [ENTRY_BITS-1:0] wr_entry;

   logic [IDX_BITS-1:0]  asg_ra, asg_rb;
   logic [LOC_BITS-1:0]  asg_da, asg_db;
   logic [ADDR_BITS-1:0] cost_ra, cost_rb, dist_ra, dist_rb;
   logic [ENTRY_BITS-1:0] cost_da, cost_db, dist_da, dist_db;
   logic                 loc_ok, pb_ok, pr_ok;

   logic signed [DIFF_BITS-1:0] ca, cb, da, db;
   logic signed [SAT_BITS-1:0]  acc_wide;

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;
   assign load           = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.payload.answer = answer_ff;

   // Command decode
   assign row_ok = int'(req_chan.payload.row_index) < MAX_SIZE;
   assign col_ok = int'(req_chan.payload.col_index) < MAX_SIZE;
   assign n_calc = (NW'(size_ff) < NW'(MAX_SIZE)) ? NW'(size_ff) : NW'(MAX_SIZE);

   assign cmd_obj_go  = (req_chan.payload.mode == MODE_OBJECTIVE) && (n_calc >= NW'(2));
   assign cmd_swap_go = (req_chan.payload.mode == MODE_SWAP)
                        && (NW'(req_chan.payload.row_index) < n_calc)
                        && (NW'(req_chan.payload.col_index) < n_calc)
                        && (req_chan.payload.row_index != req_chan.payload.col_index);

   assign n_last    = IDX_BITS'(n_ff - NW'(1));
   assign n_last2   = IDX_BITS'(n_ff - NW'(2));
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   // Store writes
   assign wr_mat_addr = mat_addr(IDX_BITS'(req_chan.payload.row_index),
                                 IDX_BITS'(req_chan.payload.col_index));
   assign wr_entry    = ENTRY_BITS'(req_chan.payload.entry_value);
   assign cost_we = req_fire && (req_chan.payload.mode == MODE_COST) && row_ok && col_ok;
   assign dist_we = req_fire && (req_chan.payload.mode == MODE_DIST) && row_ok && col_ok;
   assign asg_we  = req_fire && (req_chan.payload.mode == MODE_ASSIGN) && row_ok;

   qap_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_cost_ram (
      .clock     (clock),
      .wr_en     (cost_we),
      .wr_addr   (wr_mat_addr),
      .wr_data   (wr_entry),
      .rd_a_addr (cost_ra),
      .rd_a_data (cost_da),
      .rd_b_addr (cost_rb),
      .rd_b_data (cost_db)
   );

   qap_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_dist_ram (
      .clock     (clock),
      .wr_en     (dist_we),
      .wr_addr   (wr_mat_addr),
      .wr_data   (wr_entry),
      .rd_a_addr (dist_ra),
      .rd_a_data (dist_da),
      .rd_b_addr (dist_rb),
      .rd_b_data (dist_db)
   );

   qap_ram #(.WIDTH(LOC_BITS), .DEPTH(MAX_SIZE)) u_asg_ram (
      .clock     (clock),
      .wr_en     (asg_we),
      .wr_addr   (IDX_BITS'(req_chan.payload.row_index)),
      .wr_data   (req_chan.payload.entry_value[LOC_BITS-1:0]),
      .rd_a_addr (asg_ra),
      .rd_a_data (asg_da),
      .rd_b_addr (asg_rb),
      .rd_b_data (asg_db)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (cmd_obj_go) begin
                  state_in = ST_ROW;
               end else if (cmd_swap_go) begin
                  state_in = ST_SWAP_R;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ROW:    state_in = ST_STREAM;
         ST_SWAP_R: state_in = ST_SWAP_S;
         ST_SWAP_S: state_in = ST_STREAM;
         ST_STREAM: begin
            if (swap_ff) begin
               if (i_ff == n_last) begin
                  state_in = ST_DRAIN;
               end
            end else if (j_ff == n_last) begin
               state_in = (i_ff == n_last2) ? ST_DRAIN : ST_ROW;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer counters and issue stage
   always_comb begin
      n_in    = n_ff;
      swap_in = swap_ff;
      r_in    = r_ff;
      s_in    = s_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      pr_in   = pr_ff;
      v1_in   = 1'b0;
      a1_in   = i_ff;
      b1_in   = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in    = n_calc;
               swap_in = (req_chan.payload.mode == MODE_SWAP);
               r_in    = IDX_BITS'(req_chan.payload.row_index);
               s_in    = IDX_BITS'(req_chan.payload.col_index);
               i_in    = '0;
               j_in    = IDX_BITS'(1);
            end
         end
         ST_SWAP_S: pr_in = asg_db;
         ST_STREAM: begin
            if (swap_ff) begin
               v1_in = (i_ff != r_ff) && (i_ff != s_ff);
               if (i_ff != n_last) begin
                  i_in = i_ff + IDX_BITS'(1);
               end
            end else begin
               v1_in = 1'b1;
               if (j_ff == n_last) begin
                  if (i_ff != n_last2) begin
                     i_in = i_ff + IDX_BITS'(1);
                     j_in = i_ff + IDX_BITS'(2);
                  end
               end else begin
                  j_in = j_ff + IDX_BITS'(1);
               end
            end
         end
         ST_ROW, ST_SWAP_R, ST_DRAIN, ST_FINISH: ;
         default: ;
      endcase
   end

   // Assignment reads: port A streams, port B holds the row or swap location
   assign asg_ra = swap_ff ? i_ff : j_ff;
   assign asg_rb = swap_ff ? ((state_ff == ST_SWAP_R) ? r_ff : s_ff) : i_ff;

   // Matrix lookup stage
   assign loc_ok = int'(asg_da) < MAX_SIZE;
   assign pb_ok  = int'(asg_db) < MAX_SIZE;
   assign pr_ok  = int'(pr_ff) < MAX_SIZE;

   always_comb begin
      if (swap_ff) begin
         cost_ra = mat_addr(a1_ff, r_ff);
         cost_rb = mat_addr(a1_ff, s_ff);
         dist_ra = mat_addr(IDX_BITS'(asg_da), IDX_BITS'(asg_db));
         dist_rb = mat_addr(IDX_BITS'(asg_da), IDX_BITS'(pr_ff));
         dva2_in = loc_ok && pb_ok;
         dvb2_in = loc_ok && pr_ok;
      end else begin
         cost_ra = mat_addr(a1_ff, b1_ff);
         cost_rb = cost_ra;
         dist_ra = mat_addr(IDX_BITS'(asg_db), IDX_BITS'(asg_da));
         dist_rb = dist_ra;
         dva2_in = loc_ok && pb_ok;
         dvb2_in = 1'b0;
      end
   end

   // Difference, product and accumulate stages
   always_comb begin
      ca = signed'({1'b0, cost_da});
      cb = swap_ff ? signed'({1'b0, cost_db}) : '0;
      da = dva2_ff ? signed'({1'b0, dist_da}) : '0;
      db = dvb2_ff ? signed'({1'b0, dist_db}) : '0;
      cdiff3_in = ca - cb;
      ddiff3_in = da - db;
      prod4_in  = cdiff3_ff * ddiff3_ff;
      if (req_fire) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod4_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // Saturate and present the response
   always_comb begin
      acc_wide = SAT_BITS'(acc_ff);
      if (acc_wide > SAT_MAX) begin
         answer_in = ANS_MAX;
      end else if (acc_wide < SAT_MIN) begin
         answer_in = ANS_MIN;
      end else begin
         answer_in = ANSWER_BITS'(acc_wide);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      size_in = csr_fire ? csr_chan.payload.problem_size : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         swap_ff      <= swap_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      r_ff      <= r_in;
      s_ff      <= s_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      pr_ff     <= pr_in;
      a1_ff     <= a1_in;
      b1_ff     <= b1_in;
      dva2_ff   <= dva2_in;
      dvb2_ff   <= dvb2_in;
      cdiff3_ff <= cdiff3_in;
      ddiff3_ff <= ddiff3_in;
      prod4_ff  <= prod4_in;
      acc_ff    <= acc_in;
      if (load) begin
         answer_ff <= answer_in;
      end
   end

endmodule

// File: sv/qap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qap_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module qap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// File: sv/qap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qap_checker: port-level checks of the QAP evaluator
// Tracks commands in flight and checks responses and stalls against them.
// ----------------------------------------------------------------------------
module qap_checker
   import qap_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [ANSWER_BITS-1:0] answer
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + 2'(req_xfer) - 2'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 2'd2)
      else $error("more than two commands in flight");

   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a command");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("command taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(answer)))
      else $error("stalled response changed");

endmodule

bind qap_objective_and_swap_delta qap_checker u_qap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .answer    (rsp_chan.payload.answer)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the QAP objective and swap-delta evaluator
// Fills the cost, distance and assignment stores, then runs directed and
// random command streams at several problem sizes. A behavioral predictor
// works out each answer at acceptance, and each response transfer is checked
// in order. Both channels idle at random; the response side also holds off
// for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import qap_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_C = 3'd7;
   localparam int IDLE_PERCENT = 28;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset;

   qap_chan_if #(.payload_type(req_payload_type)) req_if ();
   qap_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   qap_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   qap_objective_and_swap_delta DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   logic [QAP_ENTRY_BITS-1:0] cost_mat [QAP_MAX_SIZE][QAP_MAX_SIZE];
   logic [QAP_ENTRY_BITS-1:0] dist_mat [QAP_MAX_SIZE][QAP_MAX_SIZE];
   logic [LOC_BITS-1:0]       location_of [QAP_MAX_SIZE];
   logic [SIZE_BITS-1:0]      configured_size;

   logic signed [ANSWER_BITS-1:0] pending_answers [$];
   int  mismatch_count;
   bit  quiet_stretch;
   bit  hold_rsp_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time, pending_answers.size());
      $display("tb: failure");
      $finish;
   end

   // update the stores and work out the answer of one accepted command
   function automatic logic signed [ANSWER_BITS-1:0] predict_answer(req_payload_type cmd);
      longint acc;
      int n;
      int r;
      int s;
      logic [LOC_BITS-1:0] loc;
      acc = 0;
      n = (configured_size < QAP_MAX_SIZE) ? int'(configured_size) : QAP_MAX_SIZE;
      r = int'(cmd.row_index);
      s = int'(cmd.col_index);
      case (cmd.mode)
         MODE_COST:   cost_mat[r][s] = cmd.entry_value;
         MODE_DIST:   dist_mat[r][s] = cmd.entry_value;
         MODE_ASSIGN: location_of[r] = cmd.entry_value[LOC_BITS-1:0];
         MODE_OBJECTIVE: begin
            for (int i = 0; i + 1 < n; i++) begin
               for (int j = i + 1; j < n; j++) begin
                  acc += longint'(cost_mat[i][j]) *
                         longint'(dist_mat[location_of[i]][location_of[j]]);
               end
            end
         end
         MODE_SWAP: begin
            if (r < n && s < n) begin
               for (int i = 0; i < n; i++) begin
                  if (i != r && i != s) begin
                     loc = location_of[i];
                     acc += (longint'(cost_mat[i][r]) - longint'(cost_mat[i][s])) *
                            (longint'(dist_mat[loc][location_of[s]]) -
                             longint'(dist_mat[loc][location_of[r]]));
                  end
               end
            end
         end
         default: ;
      endcase
      if (acc > 64'sd549755813887) acc = 64'sd549755813887;
      if (acc < -64'sd549755813888) acc = -64'sd549755813888;
      return acc[ANSWER_BITS-1:0];
   endfunction

   function automatic req_payload_type make_cmd(logic [MODE_BITS-1:0] mode, int row, int col,
                                                logic [VALUE_BITS-1:0] value);
      req_payload_type cmd;
      cmd.mode        = mode;
      cmd.row_index   = row[INDEX_BITS-1:0];
      cmd.col_index   = col[INDEX_BITS-1:0];
      cmd.entry_value = value;
      return cmd;
   endfunction

   function automatic req_payload_type random_command();
      req_payload_type cmd;
      int pick;
      pick = $urandom_range(99);
      cmd.row_index = INDEX_BITS'($urandom_range(15));
      cmd.col_index = INDEX_BITS'($urandom_range(15));
      case ($urandom_range(7))
         0:       cmd.entry_value = '0;
         1:       cmd.entry_value = '1;
         default: cmd.entry_value = VALUE_BITS'($urandom_range(65535));
      endcase
      if (pick < 22)      cmd.mode = MODE_COST;
      else if (pick < 44) cmd.mode = MODE_DIST;
      else if (pick < 56) cmd.mode = MODE_ASSIGN;
      else if (pick < 74) cmd.mode = MODE_OBJECTIVE;
      else if (pick < 96) begin
         cmd.mode = MODE_SWAP;
         if ($urandom_range(99) < 15) cmd.col_index = cmd.row_index;
      end else begin
         case ($urandom_range(2))
            0:       cmd.mode = MODE_SPARE_A;
            1:       cmd.mode = MODE_SPARE_B;
            default: cmd.mode = MODE_SPARE_C;
         endcase
      end
      return cmd;
   endfunction

   task automatic send_command(input req_payload_type cmd);
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= cmd;
      do @(posedge clock); while (!req_if.ready);
      pending_answers.push_back(predict_answer(cmd));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_size(input int size);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= csr_payload_type'(size[SIZE_BITS-1:0]);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      configured_size = size[SIZE_BITS-1:0];
   endtask

   // response side: check each transfer, then pick ready for the next edge
   initial begin : response_monitor
      logic signed [ANSWER_BITS-1:0] want;
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_if.payload.answer);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_if.payload.answer !== want) begin
                  $display("%0t: answer mismatch, expected %0d, actual %0d",
                           $time, want, rsp_if.payload.answer);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic test_fill_stores();
      for (int r = 0; r < QAP_MAX_SIZE; r++) begin
         for (int c = 0; c < QAP_MAX_SIZE; c++) begin
            send_command(make_cmd(MODE_COST, r, c, VALUE_BITS'($urandom_range(65535))));
            send_command(make_cmd(MODE_DIST, r, c, VALUE_BITS'($urandom_range(65535))));
         end
         send_command(make_cmd(MODE_ASSIGN, r, 0, VALUE_BITS'($urandom_range(65535))));
      end
   endtask

   task automatic test_directed();
      // reset size first, then the largest single product
      send_command(make_cmd(MODE_OBJECTIVE, 0, 0, 16'h0000));
      wait_idle();
      write_size(2);
      send_command(make_cmd(MODE_ASSIGN, 0, 0, 16'hFFF0));
      send_command(make_cmd(MODE_ASSIGN, 1, 0, 16'h0001));
      send_command(make_cmd(MODE_COST, 0, 1, 16'hFFFF));
      send_command(make_cmd(MODE_DIST, 0, 1, 16'hFFFF));
      send_command(make_cmd(MODE_OBJECTIVE, 15, 15, 16'hFFFF));
      wait_idle();
      // most negative single swap term, equal positions, positions past the size
      write_size(3);
      send_command(make_cmd(MODE_ASSIGN, 2, 0, 16'h0002));
      send_command(make_cmd(MODE_COST, 2, 0, 16'hFFFF));
      send_command(make_cmd(MODE_COST, 2, 1, 16'h0000));
      send_command(make_cmd(MODE_DIST, 2, 0, 16'hFFFF));
      send_command(make_cmd(MODE_DIST, 2, 1, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 0, 1, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 1, 0, 16'hFFFF));
      send_command(make_cmd(MODE_SWAP, 1, 1, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 0, 3, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 15, 0, 16'h0000));
      send_command(make_cmd(MODE_OBJECTIVE, 0, 0, 16'h0000));
      send_command(make_cmd(MODE_SPARE_A, 15, 15, 16'hFFFF));
      send_command(make_cmd(MODE_SPARE_B, 15, 15, 16'hFFFF));
      send_command(make_cmd(MODE_SPARE_C, 15, 15, 16'hFFFF));
      wait_idle();
      // empty sums and a size above the store
      write_size(0);
      send_command(make_cmd(MODE_OBJECTIVE, 0, 0, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 0, 1, 16'h0000));
      wait_idle();
      write_size(1);
      send_command(make_cmd(MODE_OBJECTIVE, 0, 0, 16'h0000));
      wait_idle();
      write_size(31);
      send_command(make_cmd(MODE_OBJECTIVE, 0, 0, 16'h0000));
      send_command(make_cmd(MODE_SWAP, 15, 0, 16'h0000));
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_size(5);
      hold_rsp_request = 1'b1;
      for (int k = 0; k < 40; k++) send_command(random_command());
      wait_idle();
   endtask

   task automatic test_random_mix();
      int size;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       size = 16;
            1:       size = 2;
            2:       size = 31;
            3:       size = 1;
            5:       size = 0;
            default: size = $urandom_range(16, 3);
         endcase
         write_size(size);
         quiet_stretch = (phase == 6);
         for (int k = 0; k < 100; k++) send_command(random_command());
         wait_idle();
         quiet_stretch = 1'b0;
      end
   endtask

   initial begin
      mismatch_count   = 0;
      quiet_stretch    = 1'b0;
      hold_rsp_request = 1'b0;
      configured_size  = SIZE_RESET;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_fill_stores();
      test_directed();
      test_backpressure();
      test_random_mix();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $display("%0t: %0d responses missing, expected %0d, actual none",
                  $time, pending_answers.size(), pending_answers[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
